// ===== hdl/ccmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccmc_pkg
// Shared types and constants for the minimum-coin table engine.
// ----------------------------------------------------------------------------
package ccmc_pkg;

	localparam int MAX_SUM     = 1023;
	localparam int DEPTH       = MAX_SUM + 1;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = 11;
	localparam int COIN_W      = 16;
	localparam int TGT_W       = 10;
	localparam int OUT_CNT_W   = 10;
	localparam int CMP_W       = 17;
	localparam int COUNT_LIMIT = 1023;

	localparam logic [CNT_W-1:0] UNREACH = {CNT_W{1'b1}};

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [COIN_W-1:0] coin_value;
		logic [TGT_W-1:0]  target_sum;
	} in_item_t;

	typedef struct packed {
		logic                 reachable;
		logic [OUT_CNT_W-1:0] min_coins;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_QUERY
	} ccmc_state_t;

	typedef struct packed {
		logic clear_start;
		logic sweep_wr;
		logic load_walk;
		logic walk_issue;
		logic query_rd;
		logic out_load;
	} ccmc_cmd_t;

	typedef struct packed {
		logic coin_ok;
		logic idx_last;
		logic out_free;
	} ccmc_sts_t;

endpackage

// ===== hdl/ccmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccmc_ctrl
// Sequencer for table clear sweeps, coin walks and query reads.
// ----------------------------------------------------------------------------
module ccmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_type,
	output logic                req_ready,
	input  ccmc_pkg::ccmc_sts_t sts,
	output ccmc_pkg::ccmc_cmd_t cmd
);

	ccmc_pkg::ccmc_state_t state_q;
	ccmc_pkg::ccmc_state_t state_d;
	logic                  xfer;

	assign req_ready = (state_q == ccmc_pkg::ST_IDLE);
	assign xfer      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccmc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ccmc_pkg::ST_CLEAR: begin
				if (sts.idx_last) begin
					state_d = ccmc_pkg::ST_IDLE;
				end
			end
			ccmc_pkg::ST_IDLE: begin
				if (xfer) begin
					case (req_type)
						ccmc_pkg::REQ_CLEAR: state_d = ccmc_pkg::ST_CLEAR;
						ccmc_pkg::REQ_ADD: begin
							if (sts.coin_ok) begin
								state_d = ccmc_pkg::ST_WALK;
							end
						end
						ccmc_pkg::REQ_QUERY: state_d = ccmc_pkg::ST_QUERY;
						default: state_d = ccmc_pkg::ST_IDLE;
					endcase
				end
			end
			ccmc_pkg::ST_WALK: begin
				if (sts.idx_last) begin
					state_d = ccmc_pkg::ST_DRAIN;
				end
			end
			ccmc_pkg::ST_DRAIN: state_d = ccmc_pkg::ST_IDLE;
			ccmc_pkg::ST_QUERY: begin
				if (sts.out_free) begin
					state_d = ccmc_pkg::ST_IDLE;
				end
			end
			default: state_d = ccmc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ccmc_pkg::ST_CLEAR: cmd.sweep_wr = 1'b1;
			ccmc_pkg::ST_IDLE: begin
				cmd.clear_start = xfer && (req_type == ccmc_pkg::REQ_CLEAR);
				cmd.load_walk   = xfer && (req_type == ccmc_pkg::REQ_ADD) && sts.coin_ok;
				cmd.query_rd    = xfer && (req_type == ccmc_pkg::REQ_QUERY);
			end
			ccmc_pkg::ST_WALK:  cmd.walk_issue = 1'b1;
			ccmc_pkg::ST_DRAIN: cmd = '0;
			ccmc_pkg::ST_QUERY: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/ccmc_datapath.sv =====
// ----------------------------------------------------------------------------
// ccmc_datapath
// Count table memory, walk index, relaxation stage and result register.
// ----------------------------------------------------------------------------
module ccmc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ccmc_pkg::in_item_t  req,
	input  ccmc_pkg::ccmc_cmd_t cmd,
	output ccmc_pkg::ccmc_sts_t sts,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ccmc_pkg::out_item_t rsp
);

	logic [ccmc_pkg::CNT_W-1:0]  mem [ccmc_pkg::DEPTH];

	logic [ccmc_pkg::IDX_W-1:0]  idx_q;
	logic [ccmc_pkg::IDX_W-1:0]  coin_q;
	logic [ccmc_pkg::IDX_W-1:0]  idx_s1;
	logic                        valid_s1;
	logic                        first_s1;
	logic [ccmc_pkg::CNT_W-1:0]  rda_q;
	logic [ccmc_pkg::CNT_W-1:0]  rdb_q;
	logic [ccmc_pkg::CNT_W-1:0]  fwd_q;
	logic                        tgt_ok_q;
	logic                        out_valid_q;
	ccmc_pkg::out_item_t         out_q;

	logic                        rda_en;
	logic [ccmc_pkg::IDX_W-1:0]  rda_addr;
	logic [ccmc_pkg::IDX_W-1:0]  rdb_addr;
	logic                        we;
	logic [ccmc_pkg::IDX_W-1:0]  wa;
	logic [ccmc_pkg::CNT_W-1:0]  wd;
	logic [ccmc_pkg::CNT_W-1:0]  prev;
	logic [ccmc_pkg::CNT_W-1:0]  cand;
	logic [ccmc_pkg::CNT_W-1:0]  relaxed;
	logic                        coin_one;
	logic                        reach;
	logic [ccmc_pkg::OUT_CNT_W-1:0] cnt;

	assign sts.coin_ok  = (req.coin_value != '0) &&
		(req.coin_value <= ccmc_pkg::COIN_W'(ccmc_pkg::MAX_SUM));
	assign sts.idx_last = (idx_q == ccmc_pkg::IDX_W'(ccmc_pkg::MAX_SUM));
	assign sts.out_free = !out_valid_q || rsp_ready;

	assign rda_en   = cmd.query_rd || cmd.walk_issue;
	assign rda_addr = cmd.query_rd ? ccmc_pkg::IDX_W'(req.target_sum) : idx_q;
	assign rdb_addr = idx_q - coin_q;
	assign coin_one = (coin_q == ccmc_pkg::IDX_W'(1));

	// coin of one reads the entry written in the same cycle
	assign prev    = (coin_one && !first_s1) ? fwd_q : rdb_q;
	assign cand    = prev + ccmc_pkg::CNT_W'(1);
	assign relaxed = ((prev != ccmc_pkg::UNREACH) && (cand < rda_q)) ? cand : rda_q;

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = (idx_q == '0) ? '0 : ccmc_pkg::UNREACH;
		if (cmd.sweep_wr) begin
			we = 1'b1;
		end else if (valid_s1) begin
			we = 1'b1;
			wa = idx_s1;
			wd = relaxed;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rda_en) begin
			rda_q <= mem[rda_addr];
		end
		if (cmd.walk_issue) begin
			rdb_q <= mem[rdb_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_issue;
			first_s1 <= cmd.walk_issue && (idx_q == coin_q);
			if (cmd.clear_start) begin
				idx_q <= '0;
			end else if (cmd.load_walk) begin
				idx_q <= ccmc_pkg::IDX_W'(req.coin_value);
			end else if (cmd.sweep_wr || cmd.walk_issue) begin
				idx_q <= idx_q + ccmc_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_walk) begin
			coin_q <= ccmc_pkg::IDX_W'(req.coin_value);
		end
		if (cmd.walk_issue) begin
			idx_s1 <= idx_q;
		end
		if (valid_s1) begin
			fwd_q <= relaxed;
		end
		if (cmd.query_rd) begin
			tgt_ok_q <= (ccmc_pkg::CMP_W'(req.target_sum) <=
				ccmc_pkg::CMP_W'(ccmc_pkg::MAX_SUM));
		end
	end

	assign reach = tgt_ok_q && (rda_q != ccmc_pkg::UNREACH);
	assign cnt   = (rda_q > ccmc_pkg::CNT_W'(ccmc_pkg::COUNT_LIMIT)) ?
		ccmc_pkg::OUT_CNT_W'(ccmc_pkg::COUNT_LIMIT) : rda_q[ccmc_pkg::OUT_CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.reachable <= reach;
			out_q.min_coins <= reach ? cnt : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== hdl/coin_change_min_coins_dp.sv =====
// ----------------------------------------------------------------------------
// coin_change_min_coins_dp
// Unbounded coin-change engine keeping the least coin count per amount.
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_ready/req) takes clear, add-coin and query items
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one item per query only
//   clear: sweep of all 1024 count table entries (one entry per cycle), req_ready low
//   add coin c: walk of the table from c to 1023, one entry per cycle through
//     the two-read one-write table memory, with req_ready low after the
//     transfer; a zero coin or one above 1023 is dropped in the
//     transfer cycle
//   query: the table entry is read into a register, then loaded into the output
//     register once it is free; the next item is taken after that load
//   reset: a clearing pass over all 1024 entries runs first, req_ready stays low
//   rsp stall: the result is held; clear and add items are still taken,
//     a further query waits in the controller until the register frees
// ----------------------------------------------------------------------------
module coin_change_min_coins_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ccmc_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ccmc_pkg::out_item_t rsp
);

	ccmc_pkg::ccmc_cmd_t cmd;
	ccmc_pkg::ccmc_sts_t sts;

	ccmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ccmc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== hdl/ccmc_checker.sv =====
// ----------------------------------------------------------------------------
// ccmc_checker
// Port-level checks for the minimum-coin engine, bound to the top level.
// ----------------------------------------------------------------------------
module ccmc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input ccmc_pkg::in_item_t  req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input ccmc_pkg::out_item_t rsp
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.reachable |-> rsp.min_coins == '0)
		else $error("unreachable result with nonzero count");

	// clear and query transfers leave req_ready low in the cycle after
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
		(req.req_type == ccmc_pkg::REQ_CLEAR || req.req_type == ccmc_pkg::REQ_QUERY)
		|=> !req_ready)
		else $error("req_ready high right after clear or query transfer");

endmodule

bind coin_change_min_coins_dp ccmc_checker u_chk (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives clear, add-coin and query transfers into the minimum-coin engine
// and checks every query answer against a table kept inside the bench. The
// sender works in random bursts and the receiver stalls on its own pattern,
// with two long hold-offs that back the engine up into its request side.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  REQ_UNUSED   = 2'd3;
	localparam int unsigned NO_WAY       = 32'hFFFF_FFFF;
	localparam int          ITEM_GOAL    = 580;
	localparam int          IDLE_LIMIT   = 20000;
	localparam int          DRAIN_CYCLES = 2100;
	localparam int          LONG_HOLD    = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	ccmc_pkg::in_item_t  req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	ccmc_pkg::out_item_t rsp;

	ccmc_pkg::in_item_t  pending_items[$];
	ccmc_pkg::out_item_t answer_q[$];
	int unsigned         coin_table [0:ccmc_pkg::MAX_SUM];
	int                  mismatches = 0;
	int                  answers_seen = 0;
	int                  idle_cycles = 0;

	coin_change_min_coins_dp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	function automatic void clear_coin_table();
		int j;
		coin_table[0] = 0;
		for (j = 1; j <= ccmc_pkg::MAX_SUM; j++) coin_table[j] = NO_WAY;
	endfunction

	function automatic void apply_item(input ccmc_pkg::in_item_t it);
		int unsigned         c;
		int unsigned         v;
		int unsigned         sat;
		int unsigned         prev;
		int                  j;
		ccmc_pkg::out_item_t ans;
		case (it.req_type)
			ccmc_pkg::REQ_CLEAR: clear_coin_table();
			ccmc_pkg::REQ_ADD: begin
				c = it.coin_value;
				if (c != 0 && c <= ccmc_pkg::MAX_SUM) begin
					for (j = int'(c); j <= ccmc_pkg::MAX_SUM; j++) begin
						prev = coin_table[j - c];
						if (prev != NO_WAY && prev + 1 < coin_table[j])
							coin_table[j] = prev + 1;
					end
				end
			end
			ccmc_pkg::REQ_QUERY: begin
				v = (it.target_sum <= ccmc_pkg::MAX_SUM) ?
					coin_table[it.target_sum] : NO_WAY;
				if (v == NO_WAY) begin
					ans.reachable = 1'b0;
					ans.min_coins = '0;
				end else begin
					sat = (v > ccmc_pkg::COUNT_LIMIT) ? ccmc_pkg::COUNT_LIMIT : v;
					ans.reachable = 1'b1;
					ans.min_coins = sat[ccmc_pkg::OUT_CNT_W-1:0];
				end
				answer_q = {answer_q, ans};
			end
			default: ;
		endcase
	endfunction

	task automatic push_item(input logic [1:0] kind, input int unsigned coin,
		input int unsigned tgt);
		ccmc_pkg::in_item_t it;
		it.req_type   = kind;
		it.coin_value = coin[ccmc_pkg::COIN_W-1:0];
		it.target_sum = tgt[ccmc_pkg::TGT_W-1:0];
		pending_items = {pending_items, it};
	endtask

	task automatic push_query(input int unsigned tgt);
		push_item(ccmc_pkg::REQ_QUERY, $urandom_range(0, 65535), tgt);
	endtask

	task automatic push_add(input int unsigned coin);
		push_item(ccmc_pkg::REQ_ADD, coin, $urandom_range(0, 1023));
	endtask

	task automatic build_random_part();
		int nadd;
		int nq;
		int k;
		int r;
		while (pending_items.size() < ITEM_GOAL) begin
			if ($urandom_range(0, 9) < 6) begin
				push_item(ccmc_pkg::REQ_CLEAR, $urandom_range(0, 65535),
					$urandom_range(0, 1023));
			end
			nadd = $urandom_range(1, 3);
			for (k = 0; k < nadd; k++) begin
				r = $urandom_range(0, 19);
				if (r < 13) begin
					push_add($urandom_range(1, 40));
				end else if (r < 17) begin
					push_add($urandom_range(41, 1023));
				end else if (r == 17) begin
					push_add(($urandom_range(0, 1) == 0) ? 1 : 1023);
				end else if (r == 18) begin
					push_add(0);
				end else begin
					push_add($urandom_range(1024, 65535));
				end
			end
			nq = $urandom_range(3, 12);
			for (k = 0; k < nq; k++) begin
				r = $urandom_range(0, 9);
				if (r < 6) push_query($urandom_range(0, 1023));
				else if (r < 9) push_query($urandom_range(0, 63));
				else push_query(($urandom_range(0, 1) == 0) ? 0 : 1023);
			end
			if ($urandom_range(0, 9) == 0)
				push_item(REQ_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 1023));
		end
	endtask

	// sender: bursts of transfers separated by random gaps
	always @(posedge clk) begin : driver_p
		logic               nxt_valid;
		ccmc_pkg::in_item_t nxt_item;
		int                 burst_left;
		int                 gap_left;
		nxt_valid = req_valid;
		nxt_item  = req;
		if (!arst_n) begin
			nxt_valid  = 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (req_valid && req_ready) begin
				apply_item(req);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0) begin
					nxt_item  = pending_items.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
		req_valid <= nxt_valid;
		req       <= nxt_item;
	end

	// receiver: changing stall modes plus two long hold-offs
	always @(posedge clk) begin : receiver_p
		logic nxt_ready;
		int   mode;
		int   mode_left;
		int   hold_left;
		bit   hold1_done;
		bit   hold2_done;
		nxt_ready = 1'b0;
		if (!arst_n) begin
			mode       = 0;
			mode_left  = 0;
			hold_left  = 0;
			hold1_done = 1'b0;
			hold2_done = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else if (!hold1_done && answers_seen >= 100) begin
			hold1_done = 1'b1;
			hold_left  = LONG_HOLD;
		end else if (!hold2_done && answers_seen >= 350) begin
			hold2_done = 1'b1;
			hold_left  = LONG_HOLD;
		end else begin
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(64, 256);
			end else begin
				mode_left--;
			end
			case (mode)
				0: nxt_ready = 1'b1;
				1: nxt_ready = ($urandom_range(0, 1) == 1);
				default: nxt_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
		rsp_ready <= nxt_ready;
	end

	// answer checker
	always @(posedge clk) begin : monitor_p
		ccmc_pkg::out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			answers_seen <= answers_seen + 1;
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer: reachable=%0d min_coins=%0d",
						rsp.reachable, rsp.min_coins);
			end else begin
				want = answer_q.pop_front();
				if (rsp.reachable !== want.reachable || rsp.min_coins !== want.min_coins) begin
					mismatches++;
					if (mismatches <= 10)
						$display("answer mismatch: expected %0d/%0d, got %0d/%0d",
							want.reachable, want.min_coins, rsp.reachable, rsp.min_coins);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog_p
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		clear_coin_table();

		// fresh table, ignored coins, unused request code
		push_query(0);
		push_query(1023);
		push_query(1);
		push_add(0);
		push_add(1024);
		push_add(65535);
		push_item(REQ_UNUSED, 65535, 1023);
		push_query(0);
		// largest coin, then unit coin for the longest count
		push_add(1023);
		push_query(1023);
		push_query(1022);
		push_add(1);
		push_query(1022);
		push_query(1023);
		push_item(ccmc_pkg::REQ_CLEAR, 65535, 1023);
		push_query(0);
		push_query(1023);
		push_add(3);
		push_add(5);
		push_query(7);
		push_query(8);
		push_query(11);
		push_query(1);

		build_random_part();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || req_valid) @(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (answer_q.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
